### hdl/rfce_pkg.sv
package rfce_pkg;

    // Frame layout: two phases of red, green, blue, slew, time.
    localparam int PHASE_BYTES     = 5;
    localparam int FRAME_USED      = 2 * PHASE_BYTES;
    localparam int IDX_W           = $clog2(FRAME_USED);
    localparam int POS_W           = 5;
    localparam int LEFT_W          = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int OFS_RED   = 0;
    localparam int OFS_GREEN = 1;
    localparam int OFS_BLUE  = 2;
    localparam int OFS_SLEW  = 3;
    localparam int OFS_TIME  = 4;

    localparam logic [7:0] DIV_RESET = 8'd3;
    localparam logic [3:0] HDR_TAG   = 4'h8;
    localparam logic [7:0] SLEW_MAX  = 8'hff;

    localparam logic [7:0] DEFAULT_FADE [FRAME_USED] = '{
        8'h80, 8'h80, 8'h80, 8'h01, 8'h80,
        8'h00, 8'h00, 8'h00, 8'h01, 8'h80
    };

    // One classified item handed from the parser to the executor.
    typedef struct packed {
        logic             wr;
        logic             rdy;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } t_cmd;

    // One result; red sits in the lowest bits.
    typedef struct packed {
        logic       phase;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_result;

    function automatic logic [7:0] to_linear(input logic [7:0] l);
        logic [7:0] v;
        if (!l[7]) begin
            v = {1'b0, l[7:1]};
        end else if (!l[6]) begin
            v = l - 8'd64;
        end else begin
            v = {l[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

### hdl/rfce_front.sv
module rfce_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_cmd,
    input  logic [7:0]          i_byte,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    output rfce_pkg::t_cmd      o_cmd
);
    import rfce_pkg::*;

    logic [7:0]        r_div;
    logic [7:0]        r_tick;
    logic [POS_W-1:0]  r_pos;
    logic [LEFT_W-1:0] r_left;

    logic [7:0]        n_tick;
    logic [POS_W-1:0]  n_pos;
    logic [LEFT_W-1:0] n_left;
    logic [8:0]        tick_sum;
    logic [POS_W-1:0]  idx_full;
    t_cmd              cmd;

    always_comb begin
        n_tick   = r_tick;
        n_pos    = r_pos;
        n_left   = r_left;
        tick_sum = {1'b0, r_tick} + 9'd1;
        idx_full = r_pos - POS_W'(1);
        cmd      = '0;
        cmd.data = i_byte;
        cmd.idx  = idx_full[IDX_W-1:0];
        if (i_cmd) begin
            if (tick_sum >= {1'b0, r_div}) begin
                n_tick   = '0;
                cmd.step = 1'b1;
            end else begin
                n_tick = tick_sum[7:0];
            end
        end else if (r_pos == '0) begin
            if (i_byte[7:4] == HDR_TAG) begin
                n_pos  = POS_W'(1);
                n_left = i_byte[3:0];
            end else begin
                n_pos  = '0;
                n_left = '0;
            end
        end else begin
            if (r_left != '0) begin
                // drop bytes beyond the phase data, keep counting
                cmd.wr = (idx_full < POS_W'(FRAME_USED));
                n_pos  = r_pos + POS_W'(1);
                n_left = r_left - LEFT_W'(1);
            end
            if (n_left == '0) begin
                cmd.rdy = 1'b1;
                n_pos   = '0;
            end
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= DIV_RESET;
            r_tick <= '0;
            r_pos  <= '0;
            r_left <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_div <= i_cfg_data;
            end
            if (i_take) begin
                r_tick <= n_tick;
                r_pos  <= n_pos;
                r_left <= n_left;
            end
        end
    end

endmodule

### hdl/rfce_queue.sv
module rfce_queue #(
    parameter int DEPTH = rfce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfce_pkg::t_cmd i_data,
    output logic           o_full,
    output logic           o_valid,
    output rfce_pkg::t_cmd o_data,
    input  logic           i_pop
);
    import rfce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

### hdl/rfce_back.sv
module rfce_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rfce_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    output rfce_pkg::t_result o_result,
    input  logic              i_out_ready
);
    import rfce_pkg::*;

    function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] tgt,
                                            input logic [7:0] slew);
        logic [7:0] v;
        if (tgt > cur) begin
            v = ((tgt - cur) > slew) ? cur + slew : tgt;
        end else begin
            v = ((cur - tgt) > slew) ? cur - slew : tgt;
        end
        return v;
    endfunction

    logic [7:0] r_buf [2][FRAME_USED];
    logic       r_act;
    logic       r_rdy;
    logic       r_phase;
    logic [7:0] r_ptime;
    logic [7:0] r_log [3];
    logic       r_out_valid;
    t_result    r_out;

    logic       pop;
    logic       rsel;
    logic       rph;
    logic [7:0] base_pt;
    logic [7:0] pt_inc;
    logic [7:0] fld [PHASE_BYTES];
    logic [7:0] slew;
    logic [7:0] step_log [3];
    logic [7:0] res_log [3];
    logic       n_phase;
    logic [7:0] n_ptime;
    logic       res_phase;

    assign pop   = i_valid && (!r_out_valid || i_out_ready);
    assign o_pop = pop;

    always_comb begin
        // a pending frame takes over at this step: read it from phase 0
        rsel    = r_rdy ? ~r_act : r_act;
        rph     = r_rdy ? 1'b0 : r_phase;
        base_pt = r_rdy ? 8'd0 : r_ptime;
        for (int k = 0; k < PHASE_BYTES; k++) begin
            fld[k] = rph ? (rsel ? r_buf[1][PHASE_BYTES + k] : r_buf[0][PHASE_BYTES + k])
                         : (rsel ? r_buf[1][k] : r_buf[0][k]);
        end
        slew = (fld[OFS_SLEW] == 8'd0) ? SLEW_MAX : fld[OFS_SLEW];
        step_log[0] = approach(r_log[0], fld[OFS_RED], slew);
        step_log[1] = approach(r_log[1], fld[OFS_GREEN], slew);
        step_log[2] = approach(r_log[2], fld[OFS_BLUE], slew);
        pt_inc  = base_pt + 8'd1;
        n_ptime = base_pt;
        n_phase = rph;
        if (fld[OFS_TIME] != 8'd0) begin
            if (pt_inc >= fld[OFS_TIME]) begin
                n_ptime = 8'd0;
                n_phase = ~rph;
            end else begin
                n_ptime = pt_inc;
            end
        end
        for (int c = 0; c < 3; c++) begin
            res_log[c] = i_cmd.step ? step_log[c] : r_log[c];
        end
        res_phase = i_cmd.step ? n_phase : r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAME_USED; k++) begin
                r_buf[0][k] <= 8'd0;
                r_buf[1][k] <= DEFAULT_FADE[k];
            end
            r_act   <= 1'b0;
            r_rdy   <= 1'b1;
            r_phase <= 1'b0;
            r_ptime <= 8'd0;
            for (int c = 0; c < 3; c++) begin
                r_log[c] <= 8'd0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (i_cmd.wr) begin
                    r_buf[~r_act][i_cmd.idx] <= i_cmd.data;
                end
                if (i_cmd.rdy) begin
                    r_rdy <= 1'b1;
                end
                if (i_cmd.step) begin
                    for (int c = 0; c < 3; c++) begin
                        r_log[c] <= step_log[c];
                    end
                    r_phase <= n_phase;
                    r_ptime <= n_ptime;
                    if (r_rdy) begin
                        r_rdy <= 1'b0;
                        r_act <= ~r_act;
                        for (int k = 0; k < FRAME_USED; k++) begin
                            r_buf[r_act][k] <= 8'd0;
                        end
                    end
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.red   <= to_linear(res_log[0]);
            r_out.green <= to_linear(res_log[1]);
            r_out.blue  <= to_linear(res_log[2]);
            r_out.phase <= res_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

### hdl/rgb_fade_command_engine_core.sv
// RGB fade command engine. Each input beat is either a received command byte
// (tuser = 0) or one base tick (tuser = 1), and each input beat yields exactly
// one output beat carrying the red, green and blue linear levels and the
// current animation phase after that beat. Command bytes are parsed as a
// header 0x8N followed by N payload bytes that fill the pending frame; once
// the payload is done the frame is marked ready and takes over at the next
// animation step. An animation step runs every step_divider ticks (a divider
// of zero acts as one); it walks each log-scale channel toward the phase
// target by at most the phase slew (a slew of zero acts as 255) and toggles
// the phase after the phase time in steps (never, for a time of zero).
// Write step_divider on the cfg channel only while the block is idle; it is
// always ready. Rate: one beat per clock through the command queue and the
// output register; parser and executor never stall on their own, so output
// backpressure alone sets throughput. After reset the pending frame holds a
// default two-phase fade and is marked ready, so the first step starts it.
module rgb_fade_command_engine_core #(
    parameter int QUEUE_DEPTH = rfce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] red_level, [15:8] green_level,
                                        // [23:16] blue_level, [24] phase_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data      // step_divider
);
    import rfce_pkg::*;

    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    take;
    t_cmd    f_cmd;
    t_cmd    q_cmd;
    t_result result;

    // Accept a beat whenever the queue has room; the output side stalls alone.
    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && !q_full;
    assign o_cfg_ready   = 1'b1;

    // Classify: parse headers and payload, count ticks into steps.
    rfce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_cmd       (s_axis_tuser[0]),
        .i_byte      (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (f_cmd)
    );

    // Hold classified beats in order between the two halves.
    rfce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    // Execute: frame writes, frame swap, channel slew, phase timing.
    rfce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, result};

endmodule
